/* rtl/epde_pkg.sv */
// Shared types and constants for the embedding pair dot engine.
// Holds the request and result word layouts, request codes and the
// command/status structs between the controller and the datapath.
package epde_pkg;

  localparam int unsigned MAX_ROWS_DEF = 4096;
  localparam int unsigned MAX_DIM_DEF  = 64;
  localparam int unsigned KEY_W        = 64;
  localparam int unsigned APB_AW       = 4;

  typedef enum logic [2:0] {
    REQ_LOAD_IN     = 3'd0,
    REQ_LOAD_OUT    = 3'd1,
    REQ_DOT         = 3'd2,
    REQ_BACK        = 3'd3,
    REQ_RD_IN_GRAD  = 3'd4,
    REQ_RD_OUT_GRAD = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    REG_IN_ROWS  = 2'd0,
    REG_OUT_ROWS = 2'd1,
    REG_VLEN     = 2'd2
  } reg_e;

  typedef struct packed {
    logic        [2:0]       req_type;
    logic        [KEY_W-1:0] input_key;
    logic        [KEY_W-1:0] output_key;
    logic        [11:0]      table_row;
    logic        [5:0]       element_index;
    logic signed [15:0]      element_value;
    logic signed [15:0]      upstream_grad;
  } req_t;

  typedef struct packed {
    logic signed [47:0] score;
    logic signed [23:0] grad_value;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic cap;
    logic mod_start;
    logic clr_step;
    logic run_step;
    logic single_go;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind_run;
    logic kind_single;
    logic mod_done;
    logic elem_last;
    logic pipe_busy;
  } sts_t;

endpackage

/* rtl/epde_mod.sv */
// Iterative remainder unit: 64-bit key modulo a row count, one key bit a cycle.
// Depends on epde_pkg for the key width.
module epde_mod #(
  parameter int unsigned DIV_W = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [epde_pkg::KEY_W-1:0] key_i,
  input  logic [DIV_W-1:0]          div_i,
  output logic                      done_o,
  output logic [DIV_W-1:0]          rem_o
);
  import epde_pkg::*;

  localparam int unsigned CNT_W = $clog2(KEY_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [KEY_W-1:0] key_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W:0]   trial, dvs;

  assign trial = {rem_q, key_q[KEY_W-1]};
  assign dvs   = {1'b0, div_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring step: shift in the next key bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      rem_q <= '0;
    end else if (busy_q) begin
      key_q <= {key_q[KEY_W-2:0], 1'b0};
      if (trial >= dvs) begin
        rem_q <= DIV_W'(trial - dvs);
      end else begin
        rem_q <= trial[DIV_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/epde_ctrl.sv */
// Controller for the embedding pair dot engine: sequences clearing, key
// reduction, element passes and result hand-off. Depends on epde_pkg.
module epde_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output epde_pkg::cmd_t cmd_o,
  input  epde_pkg::sts_t sts_i
);
  import epde_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_RUN    = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.kind_run) begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_MOD;
        end else begin
          // single-element access happens here; unused codes do nothing
          cmd_o.single_go = sts_i.kind_single;
          state_d         = S_DONE;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.run_step = 1'b1;
        if (sts_i.elem_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/epde_datapath.sv */
// Datapath for the embedding pair dot engine: tables, gradient stores,
// key reduction, multiply-accumulate pipeline and result register.
// Depends on epde_pkg and epde_mod.
module epde_datapath #(
  parameter int unsigned MAX_ROWS = epde_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_DIM  = epde_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  epde_pkg::req_t                 in_data_i,
  input  epde_pkg::cmd_t                 cmd_i,
  output epde_pkg::sts_t                 sts_o,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  in_rows_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  out_rows_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]   vlen_i,
  output epde_pkg::rsp_t                 out_data_o
);
  import epde_pkg::*;

  localparam int unsigned RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned VL_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_DIM;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  function automatic logic signed [23:0] sat_add(input logic signed [23:0] g,
                                                 input logic signed [31:0] p);
    logic signed [24:0] s;
    begin
      // p >>> 12 floors toward minus infinity
      s = {g[23], g} + {{5{p[31]}}, p[31:12]};
      if (s[24] != s[23]) begin
        sat_add = s[24] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
        sat_add = s[23:0];
      end
    end
  endfunction

  req_t req_q;

  logic signed [15:0] it_mem [DEPTH];
  logic signed [15:0] ot_mem [DEPTH];
  logic signed [23:0] ig_mem [DEPTH];
  logic signed [23:0] og_mem [DEPTH];

  logic signed [15:0] it_rd_q, ot_rd_q;
  logic signed [23:0] ig_rd_q, og_rd_q;

  logic [AW-1:0]   clr_q, ib_q, ob_q, ia, oa, sa;
  logic [AW-1:0]   ia1_q, oa1_q, ia2_q, oa2_q;
  logic [VL_W-1:0] j_q;
  logic            v1_q, v2_q;

  logic signed [31:0] p_dot_q, p_og_q, p_ig_q;
  logic signed [23:0] ig2_q, og2_q;
  logic signed [47:0] acc_q;

  logic              idone, odone;
  logic [RCNT_W-1:0] irem, orem;

  logic is_dot, is_back, is_ld_in, is_ld_out, is_rd_in, is_rd_out;
  logic row_ok, elem_ok;
  logic [RCNT_W-1:0] rows_sel;

  logic              ig_we, og_we, g_re;
  logic [AW-1:0]     ig_wa, og_wa, ig_ra, og_ra;
  logic signed [23:0] ig_wd, og_wd;

  rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) req_q <= in_data_i;
  end

  assign is_dot    = (req_q.req_type == REQ_DOT);
  assign is_back   = (req_q.req_type == REQ_BACK);
  assign is_ld_in  = (req_q.req_type == REQ_LOAD_IN);
  assign is_ld_out = (req_q.req_type == REQ_LOAD_OUT);
  assign is_rd_in  = (req_q.req_type == REQ_RD_IN_GRAD);
  assign is_rd_out = (req_q.req_type == REQ_RD_OUT_GRAD);

  assign rows_sel = (is_ld_in || is_rd_in) ? in_rows_i : out_rows_i;
  assign row_ok   = (32'(req_q.table_row) < 32'(rows_sel));
  assign elem_ok  = (32'(req_q.element_index) < MAX_DIM);

  epde_mod #(.DIV_W(RCNT_W)) u_mod_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .key_i   (req_q.input_key),
    .div_i   (in_rows_i),
    .done_o  (idone),
    .rem_o   (irem)
  );

  epde_mod #(.DIV_W(RCNT_W)) u_mod_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .key_i   (req_q.output_key),
    .div_i   (out_rows_i),
    .done_o  (odone),
    .rem_o   (orem)
  );

  always_ff @(posedge clk_i) begin
    if (idone) begin
      ib_q <= AW'(RW'(irem)) * AW'(MAX_DIM);
      ob_q <= AW'(RW'(orem)) * AW'(MAX_DIM);
    end
  end

  assign ia = ib_q + AW'(j_q);
  assign oa = ob_q + AW'(j_q);
  assign sa = AW'(req_q.table_row) * AW'(MAX_DIM) + AW'(req_q.element_index);

  // control counters and pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      j_q   <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.mod_start) begin
        j_q <= '0;
      end else if (cmd_i.run_step) begin
        j_q <= j_q + 1'b1;
      end
      v1_q <= cmd_i.run_step;
      v2_q <= v1_q;
    end
  end

  // embedding tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.single_go && is_ld_in && row_ok && elem_ok) it_mem[sa] <= req_q.element_value;
    if (cmd_i.run_step) it_rd_q <= it_mem[ia];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.single_go && is_ld_out && row_ok && elem_ok) ot_mem[sa] <= req_q.element_value;
    if (cmd_i.run_step) ot_rd_q <= ot_mem[oa];
  end

  // gradient store ports: clearing sweep, read-and-clear, or update
  assign g_re  = cmd_i.run_step || cmd_i.single_go;
  assign ig_ra = cmd_i.single_go ? sa : ia;
  assign og_ra = cmd_i.single_go ? sa : oa;

  always_comb begin
    ig_we = 1'b0;
    ig_wa = ia2_q;
    ig_wd = sat_add(ig2_q, p_ig_q);
    og_we = 1'b0;
    og_wa = oa2_q;
    og_wd = sat_add(og2_q, p_og_q);
    if (cmd_i.clr_step) begin
      ig_we = 1'b1;
      ig_wa = clr_q;
      ig_wd = '0;
      og_we = 1'b1;
      og_wa = clr_q;
      og_wd = '0;
    end else if (cmd_i.single_go) begin
      ig_we = is_rd_in && row_ok && elem_ok;
      ig_wa = sa;
      ig_wd = '0;
      og_we = is_rd_out && row_ok && elem_ok;
      og_wa = sa;
      og_wd = '0;
    end else if (v2_q && is_back) begin
      ig_we = 1'b1;
      og_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ig_we) ig_mem[ig_wa] <= ig_wd;
    if (g_re) ig_rd_q <= ig_mem[ig_ra];
  end

  always_ff @(posedge clk_i) begin
    if (og_we) og_mem[og_wa] <= og_wd;
    if (g_re) og_rd_q <= og_mem[og_ra];
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.run_step) begin
      ia1_q <= ia;
      oa1_q <= oa;
    end
    if (v1_q) begin
      p_dot_q <= $signed(it_rd_q) * $signed(ot_rd_q);
      p_og_q  <= $signed(req_q.upstream_grad) * $signed(it_rd_q);
      p_ig_q  <= $signed(req_q.upstream_grad) * $signed(ot_rd_q);
      ig2_q   <= ig_rd_q;
      og2_q   <= og_rd_q;
      ia2_q   <= ia1_q;
      oa2_q   <= oa1_q;
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      acc_q <= '0;
    end else if (v2_q && is_dot) begin
      acc_q <= acc_q + {{16{p_dot_q[31]}}, p_dot_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_q.score      <= is_dot ? acc_q : '0;
      out_q.grad_value <= (is_rd_in && row_ok && elem_ok)  ? ig_rd_q :
                          (is_rd_out && row_ok && elem_ok) ? og_rd_q : '0;
      out_q.status     <= (is_ld_in || is_ld_out || is_rd_in || is_rd_out) && !row_ok;
    end
  end

  assign out_data_o = out_q;

  assign sts_o.clr_last    = (clr_q == AW'(DEPTH - 1));
  assign sts_o.kind_run    = is_dot || is_back;
  assign sts_o.kind_single = is_ld_in || is_ld_out || is_rd_in || is_rd_out;
  assign sts_o.mod_done    = idone && odone;
  assign sts_o.elem_last   = (j_q == vlen_i - 1'b1);
  assign sts_o.pipe_busy   = v1_q || v2_q;

endmodule

/* rtl/embedding_pair_dot_engine_top.sv */
// Embedding pair dot engine: request channel in, one result word out per
// request, three configuration registers on an APB-style port.
// Depends on epde_pkg, epde_ctrl and epde_datapath.
//
// Usage:
//   Requests arrive as req_t words on in_data_i under in_valid_i/in_stall_o;
//   each produces exactly one rsp_t word on out_data_o under
//   out_valid_o/out_stall_i, in request order.
//   Loads and gradient reads: the accepted request passes S_DECODE and S_DONE,
//   then out_valid_o rises and the next word is taken back in S_IDLE. Dot and
//   backward: S_DECODE, S_MOD, S_RUN, S_DRAIN, then S_DONE; bit-serial key
//   reduction of both 64-bit keys, then one row element per cycle
//   through a read, multiply and accumulate/update pipeline.
//   One request is worked on at a time; a new word is taken while the last
//   result still waits in the output register.
//   After reset the gradient stores are swept to zero, one entry a cycle,
//   MAX_ROWS*MAX_DIM entries (262144 by default); no request is taken
//   meanwhile, configuration writes are.
//   While the receiver stalls, the finished result is held and the next
//   request waits once its own result is ready.
//   Registers: 0x0 input_table_rows, 0x4 output_table_rows, 0x8 vector_length.
module embedding_pair_dot_engine_top #(
  parameter int unsigned MAX_ROWS = epde_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_DIM  = epde_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  epde_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output epde_pkg::rsp_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [epde_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import epde_pkg::*;

  localparam int unsigned RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned VL_W   = $clog2(MAX_DIM + 1);

  function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] hi);
    begin
      if (v == 32'd0) begin
        clamp = 32'd1;
      end else if (v > hi) begin
        clamp = hi;
      end else begin
        clamp = v;
      end
    end
  endfunction

  logic [RCNT_W-1:0] in_rows_q, out_rows_q;
  logic [VL_W-1:0]   vlen_q;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic [31:0]       row_clamp, vl_clamp;

  cmd_t cmd;
  sts_t sts;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_idx   = paddr[3:2];
  assign row_clamp = clamp(pwdata, 32'(MAX_ROWS));
  assign vl_clamp  = clamp(pwdata, 32'(MAX_DIM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q  <= RCNT_W'(MAX_ROWS);
      out_rows_q <= RCNT_W'(MAX_ROWS);
      vlen_q     <= VL_W'(MAX_DIM);
    end else if (wr_en) begin
      case (reg_idx)
        REG_IN_ROWS:  in_rows_q  <= row_clamp[RCNT_W-1:0];
        REG_OUT_ROWS: out_rows_q <= row_clamp[RCNT_W-1:0];
        REG_VLEN:     vlen_q     <= vl_clamp[VL_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IN_ROWS:  prdata = 32'(in_rows_q);
      REG_OUT_ROWS: prdata = 32'(out_rows_q);
      REG_VLEN:     prdata = 32'(vlen_q);
      default:      prdata = '0;
    endcase
  end

  epde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  epde_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_DIM  (MAX_DIM)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_rows_i  (in_rows_q),
    .out_rows_i (out_rows_q),
    .vlen_i     (vlen_q),
    .out_data_o (out_data_o)
  );

endmodule
